// File: rtl/ose_pkg.sv
// Shared constants and types of the operand stack engine.
package ose_pkg;

    localparam int DEPTH_DEF      = 512;
    localparam int VALUE_BITS_DEF = 32;

    // Operation codes
    localparam logic [3:0] OP_PUSH    = 4'd0;
    localparam logic [3:0] OP_POP     = 4'd1;
    localparam logic [3:0] OP_DUP     = 4'd2;
    localparam logic [3:0] OP_EXCH    = 4'd3;
    localparam logic [3:0] OP_ROLL    = 4'd4;
    localparam logic [3:0] OP_INDEX   = 4'd5;
    localparam logic [3:0] OP_CLEAR   = 4'd6;
    localparam logic [3:0] OP_COUNT   = 4'd7;
    localparam logic [3:0] OP_CLRMARK = 4'd8;
    localparam logic [3:0] OP_CNTMARK = 4'd9;
    localparam logic [3:0] OP_REVERSE = 4'd10;

    // Status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVER      = 3'd1;
    localparam logic [2:0] ST_UNDER     = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_UNMATCHED = 3'd4;

    // Datapath commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_PUSHV = 3'd1; // write input word at level, level+1
    localparam logic [2:0] CMD_RDA   = 3'd2; // read address a
    localparam logic [2:0] CMD_RDB   = 3'd3; // read address b, latch a data
    localparam logic [2:0] CMD_WRA   = 3'd4; // write held b data at a
    localparam logic [2:0] CMD_WRB   = 3'd5; // write held a data at b
    localparam logic [2:0] CMD_PUSHR = 3'd6; // push latched read data

    typedef struct packed {
        logic [2:0] op;
        logic       load_a;   // latch read data into the a holding register
        logic       load_b;
    } ose_cmd_t;

endpackage

// File: rtl/ose_ram.sv
// Generic single-port RAM with registered read.
module ose_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read one entry each cycle and write it when enabled
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// File: rtl/ose_datapath.sv
// Datapath of the operand stack engine: entry memory and holding registers.
module ose_datapath #(
    parameter int DEPTH      = ose_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ose_pkg::VALUE_BITS_DEF
) (
    input  logic                     clk,
    input  ose_pkg::ose_cmd_t        cmd,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [VALUE_BITS:0]      wword,
    output logic [VALUE_BITS:0]      rword
);

    localparam int AW = $clog2(DEPTH);

    logic [VALUE_BITS:0] hold_a_reg;
    logic [VALUE_BITS:0] hold_b_reg;
    logic [VALUE_BITS:0] ram_wdata;
    logic                ram_we;

    // Write data selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = wword;
        case (cmd.op)
            ose_pkg::CMD_PUSHV: ram_we = 1'b1;
            ose_pkg::CMD_WRA:
            begin
                ram_we    = 1'b1;
                ram_wdata = hold_b_reg;
            end
            ose_pkg::CMD_WRB:
            begin
                ram_we    = 1'b1;
                ram_wdata = hold_a_reg;
            end
            ose_pkg::CMD_PUSHR:
            begin
                ram_we    = 1'b1;
                ram_wdata = hold_a_reg;
            end
            default: ram_we = 1'b0;
        endcase
    end

    ose_ram #(.WIDTH(VALUE_BITS + 1), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (addr[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (rword)
    );

    // Holding registers for swaps and copies
    always_ff @(posedge clk)
    begin
        if (cmd.load_a)
        begin
            hold_a_reg <= rword;
        end
        if (cmd.load_b)
        begin
            hold_b_reg <= rword;
        end
    end

endmodule

// File: rtl/ose_ctrl.sv
// Controller of the operand stack engine: sequencing, checks and result.
module ose_ctrl #(
    parameter int DEPTH      = ose_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ose_pkg::VALUE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [3:0]               action,
    input  logic [31:0]              value,
    input  logic                     mark_flag,
    input  logic signed [10:0]       span,
    input  logic signed [15:0]       shift,
    input  logic signed [10:0]       position,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               status,
    output logic [9:0]               level,
    output logic [31:0]              top_value,
    output logic                     top_mark,
    output logic                     top_valid,
    output ose_pkg::ose_cmd_t        cmd,
    output logic [$clog2(DEPTH)-1:0] addr,
    output logic [VALUE_BITS:0]      wword,
    input  logic [VALUE_BITS:0]      rword
);

    localparam int AW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int MW = 16;
    localparam int CW = (LW > 11) ? LW : 11;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MOD    = 4'd1;  // shift mod span, one subtract a cycle
    localparam logic [3:0] S_FLIP   = 4'd2;  // start one reversal pass
    localparam logic [3:0] S_RDA    = 4'd3;
    localparam logic [3:0] S_RDB    = 4'd4;
    localparam logic [3:0] S_WRA    = 4'd5;
    localparam logic [3:0] S_WRB    = 4'd6;
    localparam logic [3:0] S_SCAN   = 4'd7;  // mark search
    localparam logic [3:0] S_SCANW  = 4'd8;
    localparam logic [3:0] S_COPY   = 4'd9;  // read entry to duplicate
    localparam logic [3:0] S_COPYW  = 4'd10;
    localparam logic [3:0] S_TOP    = 4'd11; // read new top
    localparam logic [3:0] S_TOPW   = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_PUSHC  = 4'd14; // push latched entry, or second write of a swap

    logic [3:0]          state_reg, state_next;
    logic [LW-1:0]       fill_reg, fill_next;
    logic [3:0]          op_reg, op_next;
    logic [2:0]          st_reg, st_next;
    logic [LW-1:0]       n_reg, n_next;       // roll span
    logic [MW:0]         amt_reg, amt_next;   // roll amount being reduced
    logic                neg_reg, neg_next;
    logic [1:0]          pass_reg, pass_next;
    logic [LW-1:0]       lo_reg, lo_next;     // low address of current reversal
    logic [LW-1:0]       hi_reg, hi_next;     // high address (inclusive)
    logic [LW-1:0]       idx_reg, idx_next;   // scan or copy address
    logic [VALUE_BITS:0] top_reg, top_next;
    logic                done_reg, done_next;

    logic [CW-1:0] span_w;
    logic [CW-1:0] pos_w;
    logic [CW-1:0] fill_w;
    logic [LW-1:0] span_u;
    logic [LW-1:0] pos_u;
    logic [LW-1:0] k_amt;
    logic [LW-1:0] cnt_word;
    logic [MW:0]   shift_mag;

    // Range checks are made at a width that holds both the operand and the depth
    assign span_w    = CW'(span[9:0]);
    assign pos_w     = CW'(position[9:0]);
    assign fill_w    = CW'(fill_reg);
    assign span_u    = LW'(span_w);
    assign pos_u     = LW'(pos_w);
    assign k_amt     = amt_reg[LW-1:0];
    assign shift_mag = shift[15] ? (MW+1)'(-$signed({shift[15], shift})) : {1'b0, shift};
    assign cnt_word  = fill_reg - LW'(1) - idx_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = st_reg;
    assign level     = 10'(fill_reg);
    assign top_valid = (fill_reg != '0);
    assign top_value = top_valid ? 32'(top_reg[VALUE_BITS-1:0]) : 32'd0;
    assign top_mark  = top_valid & top_reg[VALUE_BITS];

    // Registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        st_reg   <= st_next;
        n_reg    <= n_next;
        amt_reg  <= amt_next;
        neg_reg  <= neg_next;
        pass_reg <= pass_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        idx_reg  <= idx_next;
        top_reg  <= top_next;
        done_reg <= done_next;
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        n_next     = n_reg;
        amt_next   = amt_reg;
        neg_next   = neg_reg;
        pass_next  = pass_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        top_next   = top_reg;
        done_next  = done_reg;
        cmd        = '{op: ose_pkg::CMD_NONE, load_a: 1'b0, load_b: 1'b0};
        addr       = AW'(fill_reg);
        wword      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = action;
                    st_next    = ose_pkg::ST_OK;
                    state_next = S_TOP;
                    case (action)
                        ose_pkg::OP_PUSH:
                        begin
                            if (fill_reg == LW'(DEPTH))
                            begin
                                st_next = ose_pkg::ST_OVER;
                            end
                            else
                            begin
                                cmd.op    = ose_pkg::CMD_PUSHV;
                                wword     = {mark_flag, VALUE_BITS'(value)};
                                fill_next = fill_reg + LW'(1);
                            end
                        end
                        ose_pkg::OP_POP:
                        begin
                            if (fill_reg == '0) st_next = ose_pkg::ST_UNDER;
                            else fill_next = fill_reg - LW'(1);
                        end
                        ose_pkg::OP_DUP:
                        begin
                            if (fill_reg == '0) st_next = ose_pkg::ST_UNDER;
                            else if (fill_reg == LW'(DEPTH)) st_next = ose_pkg::ST_OVER;
                            else
                            begin
                                idx_next   = fill_reg - LW'(1);
                                state_next = S_COPY;
                            end
                        end
                        ose_pkg::OP_EXCH:
                        begin
                            if (fill_reg < LW'(2)) st_next = ose_pkg::ST_UNDER;
                            else
                            begin
                                lo_next    = fill_reg - LW'(2);
                                hi_next    = fill_reg - LW'(1);
                                pass_next  = 2'd2;
                                state_next = S_RDA;
                            end
                        end
                        ose_pkg::OP_ROLL:
                        begin
                            if (span[10]) st_next = ose_pkg::ST_RANGE;
                            else if (span_w > fill_w) st_next = ose_pkg::ST_UNDER;
                            else if (span_w != '0)
                            begin
                                n_next     = span_u;
                                amt_next   = shift_mag;
                                neg_next   = shift[15];
                                state_next = S_MOD;
                            end
                        end
                        ose_pkg::OP_INDEX:
                        begin
                            if (position[10] || pos_w >= fill_w) st_next = ose_pkg::ST_RANGE;
                            else if (fill_reg == LW'(DEPTH)) st_next = ose_pkg::ST_OVER;
                            else
                            begin
                                idx_next   = fill_reg - LW'(1) - pos_u;
                                state_next = S_COPY;
                            end
                        end
                        ose_pkg::OP_CLEAR: fill_next = '0;
                        ose_pkg::OP_COUNT:
                        begin
                            if (fill_reg == LW'(DEPTH)) st_next = ose_pkg::ST_OVER;
                            else
                            begin
                                cmd.op    = ose_pkg::CMD_PUSHV;
                                wword     = {1'b0, VALUE_BITS'(fill_reg)};
                                fill_next = fill_reg + LW'(1);
                            end
                        end
                        ose_pkg::OP_CLRMARK, ose_pkg::OP_CNTMARK:
                        begin
                            idx_next   = fill_reg;
                            state_next = S_SCAN;
                        end
                        ose_pkg::OP_REVERSE:
                        begin
                            if (span[10] || span_w > fill_w) st_next = ose_pkg::ST_RANGE;
                            else if (span_w > CW'(1))
                            begin
                                lo_next    = fill_reg - span_u;
                                hi_next    = fill_reg - LW'(1);
                                pass_next  = 2'd2;
                                state_next = S_RDA;
                            end
                        end
                        default: st_next = ose_pkg::ST_OK;
                    endcase
                end
            end

            // Reduce the roll amount modulo the span, then set up three reversals
            S_MOD:
            begin
                if (amt_reg >= (MW+1)'(n_reg))
                begin
                    amt_next = amt_reg - (MW+1)'(n_reg);
                end
                else
                begin
                    if (neg_reg && amt_reg != '0)
                    begin
                        amt_next = (MW+1)'(n_reg) - amt_reg;
                    end
                    pass_next  = 2'd0;
                    state_next = S_FLIP;
                end
            end

            S_FLIP:
            begin
                case (pass_reg)
                    2'd0:
                    begin
                        lo_next = fill_reg - n_reg;
                        hi_next = fill_reg - LW'(1);
                    end
                    2'd1:
                    begin
                        lo_next = fill_reg - n_reg;
                        hi_next = fill_reg - n_reg + k_amt - LW'(1);
                    end
                    default:
                    begin
                        lo_next = fill_reg - n_reg + k_amt;
                        hi_next = fill_reg - LW'(1);
                    end
                endcase
                state_next = S_RDA;
            end

            // Swap lo and hi: read lo, read hi, latch both, then write each at the other
            S_RDA:
            begin
                if (lo_reg >= hi_reg || hi_reg == '1)
                begin
                    if (pass_reg >= 2'd2) state_next = S_TOP;
                    else
                    begin
                        pass_next  = pass_reg + 2'd1;
                        state_next = S_FLIP;
                    end
                end
                else
                begin
                    addr       = AW'(lo_reg);
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                addr       = AW'(hi_reg);
                cmd.load_a = 1'b1;
                state_next = S_WRA;
            end
            S_WRA:
            begin
                cmd.load_b = 1'b1;
                state_next = S_WRB;
            end
            S_WRB:
            begin
                cmd.op     = ose_pkg::CMD_WRA;
                addr       = AW'(lo_reg);
                done_next  = 1'b1;
                state_next = S_PUSHC;
            end

            // Second write of a swap and advance both pointers, or push of a copied entry
            S_PUSHC:
            begin
                if (done_reg)
                begin
                    cmd.op     = ose_pkg::CMD_WRB;
                    addr       = AW'(hi_reg);
                    lo_next    = lo_reg + LW'(1);
                    hi_next    = hi_reg - LW'(1);
                    state_next = S_RDA;
                end
                else
                begin
                    cmd.op     = ose_pkg::CMD_PUSHR;
                    addr       = AW'(fill_reg);
                    fill_next  = fill_reg + LW'(1);
                    state_next = S_TOP;
                end
            end

            // Copy an entry to the top (dup and index)
            S_COPY:
            begin
                addr       = AW'(idx_reg);
                state_next = S_COPYW;
            end
            S_COPYW:
            begin
                cmd.load_a = 1'b1;
                done_next  = 1'b0;
                state_next = S_PUSHC;
            end

            // Search downwards for a mark, reading and checking one entry at a time
            S_SCAN:
            begin
                if (idx_reg == '0)
                begin
                    st_next    = ose_pkg::ST_UNMATCHED;
                    state_next = S_TOP;
                end
                else
                begin
                    idx_next   = idx_reg - LW'(1);
                    addr       = AW'(idx_reg - LW'(1));
                    state_next = S_SCANW;
                end
            end
            S_SCANW:
            begin
                if (!rword[VALUE_BITS]) state_next = S_SCAN;
                else if (op_reg == ose_pkg::OP_CLRMARK)
                begin
                    fill_next  = idx_reg;
                    state_next = S_TOP;
                end
                else if (fill_reg == LW'(DEPTH))
                begin
                    st_next    = ose_pkg::ST_OVER;
                    state_next = S_TOP;
                end
                else
                begin
                    cmd.op     = ose_pkg::CMD_PUSHV;
                    wword      = {1'b0, VALUE_BITS'(cnt_word)};
                    fill_next  = fill_reg + LW'(1);
                    state_next = S_TOP;
                end
            end

            // Fetch the top entry for the result
            S_TOP:
            begin
                addr       = AW'(fill_reg - LW'(1));
                state_next = S_TOPW;
            end
            S_TOPW:
            begin
                top_next   = rword;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_stall) state_next = S_IDLE;
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Depth never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= LW'(DEPTH))
        else $error("depth beyond store");

    // Items are taken only when idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("item accepted while busy");

    // The depth holds while a result is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> $stable(fill_reg))
        else $error("depth changed after result");

endmodule

// File: rtl/operand_stack_engine.sv
// Top level of the operand stack engine.
//
// One operation enters on the input channel (in_valid/in_stall) with fields
// action, value, mark_flag, span, shift and position. Exactly one result
// leaves on the output channel (out_valid/out_stall): status, level and the
// top entry. One item is processed at a time; in_stall stays high from the
// transfer of an item until its result has been taken, and the next item
// can be taken in the cycle after the result transfer.
// Push, pop, clear and count update the stack and then read the new top for
// the result; dup and index first read, latch and push the chosen entry.
// Exch and reverse swap pair after pair, each swap reading both entries and
// writing them back crosswise. Roll reduces the shift by repeated subtraction
// of the span, then runs three reversals, about span swaps in all. Mark
// searches read one entry at a time. The single memory port sets these steps.
// While the receiver stalls the result holds and no new item is taken.
// Reset empties the stack at once; stored entries are not cleared.
module operand_stack_engine #(
    parameter int DEPTH      = ose_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = ose_pkg::VALUE_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [3:0]         action,
    input  logic [31:0]        value,
    input  logic               mark_flag,
    input  logic signed [10:0] span,
    input  logic signed [15:0] shift,
    input  logic signed [10:0] position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [9:0]         level,
    output logic [31:0]        top_value,
    output logic               top_mark,
    output logic               top_valid
);

    ose_pkg::ose_cmd_t          cmd;
    logic [$clog2(DEPTH)-1:0]   addr;
    logic [VALUE_BITS:0]        wword;
    logic [VALUE_BITS:0]        rword;

    ose_ctrl #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .action, .value, .mark_flag,
        .span, .shift, .position, .out_valid, .out_stall, .status, .level,
        .top_value, .top_mark, .top_valid, .cmd, .addr, .wword, .rword
    );

    ose_datapath #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
        .clk, .cmd, .addr, .wword, .rword
    );

endmodule

// File: tb/sv/operand_stack_engine_test.sv
// Self-checking testbench of the operand stack engine.
`timescale 1ns / 100ps

module operand_stack_engine_test;

    localparam int STACK_DEPTH = ose_pkg::DEPTH_DEF;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  level;
        logic [31:0] top_value;
        logic        top_mark;
        logic        top_valid;
    } stack_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [3:0]         action;
    logic [31:0]        value;
    logic               mark_flag;
    logic signed [10:0] span;
    logic signed [15:0] shift;
    logic signed [10:0] position;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         status;
    logic [9:0]         level;
    logic [31:0]        top_value;
    logic               top_mark;
    logic               top_valid;

    // Shadow copy of the stack contents and depth
    logic [31:0]     shadow_value [STACK_DEPTH];
    logic            shadow_mark  [STACK_DEPTH];
    int              shadow_depth;
    stack_result_t   pending_results [$];
    int              mismatch_count;
    int              receive_wait;
    int              hold_request;
    bit              idling_on;

    operand_stack_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .mark_flag (mark_flag),
        .span      (span),
        .shift     (shift),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .level     (level),
        .top_value (top_value),
        .top_mark  (top_mark),
        .top_valid (top_valid)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Reverses n shadow entries starting at base.
    task automatic flip_entries(input int base, input int n);
        logic [31:0] tv;
        logic        tm;
        for (int i = 0; i < n / 2; i++)
        begin
            tv = shadow_value[base + i];
            tm = shadow_mark[base + i];
            shadow_value[base + i] = shadow_value[base + n - 1 - i];
            shadow_mark[base + i] = shadow_mark[base + n - 1 - i];
            shadow_value[base + n - 1 - i] = tv;
            shadow_mark[base + n - 1 - i] = tm;
        end
    endtask

    task automatic push_entry(input logic [31:0] v, input logic mk, output logic [2:0] st);
        if (shadow_depth >= STACK_DEPTH)
        begin
            st = ose_pkg::ST_OVER;
        end
        else
        begin
            shadow_value[shadow_depth] = v;
            shadow_mark[shadow_depth] = mk;
            shadow_depth++;
            st = ose_pkg::ST_OK;
        end
    endtask

    // Distance of the topmost mark below the top, or -1 when there is none.
    function automatic int mark_distance();
        for (int i = shadow_depth - 1; i >= 0; i--)
        begin
            if (shadow_mark[i])
                return shadow_depth - 1 - i;
        end
        return -1;
    endfunction

    // Applies one operation to the shadow stack and returns the expected result.
    task automatic stack_apply(input logic [3:0] op, input logic [31:0] v, input logic mk,
                               input int sp, input int sh, input int pos,
                               output stack_result_t res);
        logic [2:0] st;
        int         d;
        int         amt;
        int         base;
        st = ose_pkg::ST_OK;
        case (op)
            ose_pkg::OP_PUSH: push_entry(v, mk, st);
            ose_pkg::OP_POP:
            begin
                if (shadow_depth == 0) st = ose_pkg::ST_UNDER;
                else shadow_depth--;
            end
            ose_pkg::OP_DUP:
            begin
                if (shadow_depth == 0) st = ose_pkg::ST_UNDER;
                else push_entry(shadow_value[shadow_depth - 1], shadow_mark[shadow_depth - 1], st);
            end
            ose_pkg::OP_EXCH:
            begin
                if (shadow_depth < 2) st = ose_pkg::ST_UNDER;
                else flip_entries(shadow_depth - 2, 2);
            end
            ose_pkg::OP_ROLL:
            begin
                if (sp < 0) st = ose_pkg::ST_RANGE;
                else if (sp > shadow_depth) st = ose_pkg::ST_UNDER;
                else if (sp > 0)
                begin
                    base = shadow_depth - sp;
                    if (sh >= 0) amt = sh % sp;
                    else amt = (sp - ((-sh) % sp)) % sp;
                    flip_entries(base, sp);
                    flip_entries(base, amt);
                    flip_entries(base + amt, sp - amt);
                end
            end
            ose_pkg::OP_INDEX:
            begin
                if (pos < 0 || pos >= shadow_depth) st = ose_pkg::ST_RANGE;
                else push_entry(shadow_value[shadow_depth - 1 - pos],
                                shadow_mark[shadow_depth - 1 - pos], st);
            end
            ose_pkg::OP_CLEAR: shadow_depth = 0;
            ose_pkg::OP_COUNT: push_entry(32'(shadow_depth), 1'b0, st);
            ose_pkg::OP_CLRMARK:
            begin
                d = mark_distance();
                if (d < 0) st = ose_pkg::ST_UNMATCHED;
                else shadow_depth = shadow_depth - d - 1;
            end
            ose_pkg::OP_CNTMARK:
            begin
                d = mark_distance();
                if (d < 0) st = ose_pkg::ST_UNMATCHED;
                else push_entry(32'(d), 1'b0, st);
            end
            ose_pkg::OP_REVERSE:
            begin
                if (sp < 0 || sp > shadow_depth) st = ose_pkg::ST_RANGE;
                else flip_entries(shadow_depth - sp, sp);
            end
            default: ;
        endcase
        res.status = st;
        res.level = 10'(shadow_depth);
        res.top_valid = (shadow_depth > 0);
        res.top_value = (shadow_depth > 0) ? shadow_value[shadow_depth - 1] : 32'd0;
        res.top_mark = (shadow_depth > 0) ? shadow_mark[shadow_depth - 1] : 1'b0;
    endtask

    // Sends one operation, waits for its transfer and records the expected result.
    task automatic send_op(input logic [3:0] op, input logic [31:0] v = 32'd0,
                           input logic mk = 1'b0, input int sp = 0, input int sh = 0,
                           input int pos = 0);
        stack_result_t res;
        int            gap;
        gap = idling_on ? $urandom_range(0, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        if (gap == 0)
            @(negedge clk);
        action <= op;
        value <= v;
        mark_flag <= mk;
        span <= 11'(sp);
        shift <= 16'(sh);
        position <= 11'(pos);
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        stack_apply(op, v, mk, sp, sh, pos, res);
        pending_results.push_back(res);
    endtask

    // Withdraws the last item before the block can take it again, then waits.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stalls per result, plus an optional long hold-off.
    initial
    begin
        int long_hold;
        out_stall = 1'b0;
        long_hold = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                long_hold = hold_request;
                hold_request = 0;
            end
            if (long_hold > 0)
            begin
                long_hold--;
                out_stall <= 1'b1;
            end
            else if (receive_wait > 0)
            begin
                receive_wait--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Compares every result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        stack_result_t exp_res;
        stack_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status, level, top_value, top_mark, top_valid};
            receive_wait = idling_on ? $urandom_range(0, 4) : 0;
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result transfer: %p", got);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (got !== exp_res)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected %p, got %p", exp_res, got);
                end
            end
        end
    end

    // Extremes of the fields and the underflow, range and unmatched cases on a short stack.
    task automatic test_directed();
        send_op(ose_pkg::OP_POP);
        send_op(ose_pkg::OP_DUP);
        send_op(ose_pkg::OP_EXCH);
        send_op(ose_pkg::OP_CLRMARK);
        send_op(ose_pkg::OP_CNTMARK);
        send_op(ose_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b1);
        send_op(ose_pkg::OP_EXCH);
        send_op(ose_pkg::OP_PUSH, 32'd0, 1'b0);
        send_op(ose_pkg::OP_COUNT);
        send_op(ose_pkg::OP_DUP);
        send_op(ose_pkg::OP_EXCH);
        send_op(ose_pkg::OP_ROLL, 0, 0, 3, 1);
        send_op(ose_pkg::OP_ROLL, 0, 0, 0, 5);
        send_op(ose_pkg::OP_ROLL, 0, 0, -1024, 0);
        send_op(ose_pkg::OP_ROLL, 0, 0, 1023, 0);
        send_op(ose_pkg::OP_ROLL, 0, 0, 4, -32768);
        send_op(ose_pkg::OP_ROLL, 0, 0, 3, 32767);
        send_op(ose_pkg::OP_INDEX, 0, 0, 0, 0, 3);
        send_op(ose_pkg::OP_INDEX, 0, 0, 0, 0, -1024);
        send_op(ose_pkg::OP_INDEX, 0, 0, 0, 0, 1023);
        send_op(ose_pkg::OP_REVERSE, 0, 0, 5);
        send_op(ose_pkg::OP_REVERSE, 0, 0, -1);
        send_op(ose_pkg::OP_REVERSE, 0, 0, 1023);
        send_op(ose_pkg::OP_CNTMARK);
        send_op(ose_pkg::OP_CLRMARK);
        send_op(4'd15);
        send_op(ose_pkg::OP_CLEAR);
        wait_drained();
    endtask

    // Fills the stack to the top under a long receiver hold-off, then overflows it.
    task automatic test_full_stack();
        hold_request = 300;
        for (int i = 0; i < STACK_DEPTH; i++)
            send_op(ose_pkg::OP_PUSH, $urandom, ($urandom_range(0, 7) == 0));
        send_op(ose_pkg::OP_PUSH, $urandom, 1'b0);
        send_op(ose_pkg::OP_DUP);
        send_op(ose_pkg::OP_INDEX, 0, 0, 0, 0, 0);
        send_op(ose_pkg::OP_COUNT);
        send_op(ose_pkg::OP_CNTMARK);
        send_op(ose_pkg::OP_ROLL, 0, 0, STACK_DEPTH, 7);
        send_op(ose_pkg::OP_ROLL, 0, 0, STACK_DEPTH, -32768);
        send_op(ose_pkg::OP_REVERSE, 0, 0, STACK_DEPTH);
        send_op(ose_pkg::OP_INDEX, 0, 0, 0, 0, STACK_DEPTH - 1);
        send_op(ose_pkg::OP_CLRMARK);
        send_op(ose_pkg::OP_CLEAR);
        wait_drained();
    endtask

    // Random operations, biased so that the depth wanders over the whole range.
    task automatic test_random(input int count);
        int target;
        int pick;
        int sp;
        int sh;
        int pos;
        target = 40;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
            begin
                target = $urandom_range(0, 3) == 0 ? $urandom_range(300, 520) : $urandom_range(2, 60);
                idling_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            sp = (shadow_depth > 0) ? $urandom_range(0, shadow_depth) : 0;
            sh = $signed(16'($urandom_range(0, 80))) - 40;
            pos = (shadow_depth > 0) ? $urandom_range(0, shadow_depth - 1) : 0;
            if ($urandom_range(0, 9) == 0)
            begin
                sp = $signed(11'($urandom));
                pos = $signed(11'($urandom));
                if (sp >= 64)
                    sh = $signed(16'($urandom));
            end
            if (shadow_depth < target && pick < 55)
                send_op(ose_pkg::OP_PUSH, $urandom, ($urandom_range(0, 9) == 0));
            else if (pick < 20)
                send_op(ose_pkg::OP_POP);
            else
                send_op(4'($urandom_range(0, 15)), $urandom, $urandom_range(0, 1), sp, sh, pos);
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ose_pkg::OP_PUSH;
        value = 32'd0;
        mark_flag = 1'b0;
        span = '0;
        shift = '0;
        position = '0;
        shadow_depth = 0;
        mismatch_count = 0;
        receive_wait = 0;
        hold_request = 0;
        idling_on = 1'b1;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_full_stack();
        test_random(800);
        repeat (50)
            @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #300_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
